### rtl/core/cbl_pkg.sv
// Shared types, operation codes and constants for the CIDR blocklist matcher.
// No dependencies; imported by cbl_table and cidr_blocklist_match.
package cbl_pkg;

	localparam int ADDR_W          = 32;
	localparam int PLEN_W          = 6;
	localparam int COUNT_W         = 13;
	localparam int MAX_ENTRIES_DEF = 4096;

	localparam logic [PLEN_W-1:0] HOST_PREFIX = PLEN_W'(32);

	// operation codes
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// one table entry
	typedef struct packed {
		logic [ADDR_W-1:0] network;
		logic [PLEN_W-1:0] plen;
	} entry_t;

	// table write request
	typedef struct packed {
		logic              en;
		logic [15:0]       idx;
		entry_t            entry;
	} wr_req_t;

	// network mask for a prefix length of 0..32
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
		logic [ADDR_W-1:0] m;
		m = ~({ADDR_W{1'b1}} >> plen);
		return m;
	endfunction

endpackage

### rtl/core/cbl_table.sv
// Entry memory of the blocklist matcher with a registered read port and
// the prefix compare on the read data. Depends on cbl_pkg.
module cbl_table #(
	parameter int MAX_ENTRIES = cbl_pkg::MAX_ENTRIES_DEF,
	parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic                       clk,
	input  cbl_pkg::wr_req_t           wr,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_idx,
	input  logic [cbl_pkg::ADDR_W-1:0] lookup_addr,
	output logic                       hit
);
	import cbl_pkg::*;

	entry_t            mem [MAX_ENTRIES];
	entry_t            rd_data_q;
	logic [ADDR_W-1:0] mask;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx[AW-1:0]] <= wr.entry;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	// prefix compare on the entry just read
	assign mask = prefix_mask(rd_data_q.plen);
	assign hit  = ((lookup_addr & mask) == (rd_data_q.network & mask));

endmodule

### rtl/core/cidr_blocklist_match.sv
// IPv4 CIDR blocklist matcher, top level.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. operation selects lookup, add entry or clear table; address
// and prefix_length carry the operands.
// Result channel: done is high for exactly one cycle per transaction, with
// matched, entry_count and status valid in that cycle. The receiver cannot
// stall; every result is taken when shown.
// Timing: add, clear, unused codes and a lookup on an empty table give
// their result in the cycle after acceptance. A lookup reads the entry memory
// one entry per cycle and compares each on the cycle after its read; the scan
// ends early on the first hit.
// busy is high while a lookup scans; other commands leave it low, so they
// can be taken every cycle. The scan through the single read port of the
// entry memory sets the lookup rate.
// Reset clears the entry count and all control state; the entry memory is
// not cleared, since only entries below the count are read.
module cidr_blocklist_match #(
	parameter int MAX_ENTRIES = cbl_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [cbl_pkg::ADDR_W-1:0]  address,
	input  logic [cbl_pkg::PLEN_W-1:0]  prefix_length,
	output logic                        done,
	output logic                        matched,
	output logic [cbl_pkg::COUNT_W-1:0] entry_count,
	output logic                        status
);
	import cbl_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic              state_q;
	logic [CW-1:0]     count_q;
	logic [ADDR_W-1:0] addr_q;
	logic [AW-1:0]     issue_idx_q;
	logic              issue_q;
	logic              vld_s1;
	logic              last_s1;
	logic              done_q;
	logic              matched_q;
	logic              status_q;

	logic              accept;
	logic              has_room;
	logic              plen_ok;
	logic              last_issue;
	logic              hit;
	logic              finish;
	logic [31:0]       count_ext;
	wr_req_t           wr;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign has_room   = (count_q < MAX_CNT);
	assign plen_ok    = (prefix_length <= HOST_PREFIX);
	assign last_issue = (CW'(issue_idx_q) == (count_q - CW'(1)));
	assign finish     = vld_s1 && (hit || last_s1);

	// append on add
	always_comb begin
		wr.en           = accept && (operation == OP_ADD) && has_room && plen_ok;
		wr.idx          = 16'(count_q);
		wr.entry.network = address;
		wr.entry.plen    = prefix_length;
	end

	cbl_table #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW)
	) u_table (
		.clk         (clk),
		.wr          (wr),
		.rd_en       (issue_q),
		.rd_idx      (issue_idx_q),
		.lookup_addr (addr_q),
		.hit         (hit)
	);

	// command decode, scan control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_q     <= 1'b0;
			issue_idx_q <= '0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			done_q      <= 1'b0;
			matched_q   <= 1'b0;
			status_q    <= STATUS_OK;
			addr_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						matched_q <= 1'b0;
						status_q  <= STATUS_OK;
						case (operation)
							OP_LOOKUP: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q     <= ST_SCAN;
									addr_q      <= address;
									issue_idx_q <= '0;
									issue_q     <= 1'b1;
								end
							end
							OP_ADD: begin
								done_q <= 1'b1;
								if (!has_room) begin
									status_q <= STATUS_FULL;
								end else if (plen_ok) begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_CLEAR: begin
								done_q  <= 1'b1;
								count_q <= '0;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// read side: one entry per cycle up to the count
					if (issue_q) begin
						issue_idx_q <= AW'(issue_idx_q + AW'(1));
						if (last_issue) begin
							issue_q <= 1'b0;
						end
					end
					vld_s1  <= issue_q && !finish;
					last_s1 <= last_issue;
					// compare side: stop on first hit or after the last entry
					if (finish) begin
						issue_q   <= 1'b0;
						state_q   <= ST_IDLE;
						done_q    <= 1'b1;
						matched_q <= hit;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// count is stable while a result is shown
	assign count_ext   = 32'(count_q);
	assign done        = done_q;
	assign matched     = matched_q;
	assign status      = status_q;
	assign entry_count = count_ext[COUNT_W-1:0];

endmodule

### tb/cidr_blocklist_match_checker.sv
// Scoreboard for the CIDR blocklist matcher: watches the command and result
// channels, predicts each result from its own copy of the entry table, and compares.
// Depends on cbl_pkg for widths, operation codes and status codes.
module cidr_blocklist_match_checker #(
	parameter int MAX_ENTRIES = cbl_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [cbl_pkg::ADDR_W-1:0]  address,
	input  logic [cbl_pkg::PLEN_W-1:0]  prefix_length,
	input  logic                        done,
	input  logic                        matched,
	input  logic [cbl_pkg::COUNT_W-1:0] entry_count,
	input  logic                        status,
	output int                          errors,
	output int                          pending,
	output int                          lookups_seen,
	output int                          lookup_hits,
	output int                          adds_dropped
);
	timeunit 1ns;
	timeprecision 1ps;

	import cbl_pkg::*;

	typedef struct packed {
		logic               matched;
		logic [COUNT_W-1:0] entry_count;
		logic               status;
	} outcome_t;

	// shadow copy of the table
	logic [ADDR_W-1:0] table_net  [MAX_ENTRIES];
	logic [PLEN_W-1:0] table_plen [MAX_ENTRIES];
	int                table_size = 0;

	outcome_t expected_q[$];

	int err_cnt   = 0;
	int n_lookups = 0;
	int n_hits    = 0;
	int n_dropped = 0;

	assign errors       = err_cnt;
	assign pending      = expected_q.size();
	assign lookups_seen = n_lookups;
	assign lookup_hits  = n_hits;
	assign adds_dropped = n_dropped;

	// apply one command to the shadow table and return the result it must give
	function automatic outcome_t apply_command(input logic [1:0] op,
		input logic [ADDR_W-1:0] addr, input logic [PLEN_W-1:0] plen);
		outcome_t          o;
		logic [ADDR_W-1:0] m;
		int                i;
		o = '0;
		o.status = STATUS_OK;
		case (op)
		OP_LOOKUP: begin
			for (i = 0; i < table_size; i++) begin
				// a zero-length prefix covers every address
				m = (table_plen[i] == '0) ? '0 :
					({ADDR_W{1'b1}} << (ADDR_W - int'(table_plen[i])));
				if (((addr ^ table_net[i]) & m) == '0)
					o.matched = 1'b1;
			end
		end
		OP_ADD: begin
			if (table_size >= MAX_ENTRIES) begin
				o.status = STATUS_FULL;
			end else if (plen <= HOST_PREFIX) begin
				// prefixes over 32 are silently ignored
				table_net[table_size]  = addr;
				table_plen[table_size] = plen;
				table_size++;
			end
		end
		OP_CLEAR: begin
			table_size = 0;
		end
		default: ;
		endcase
		o.entry_count = COUNT_W'(table_size);
		return o;
	endfunction

	// results first, then the transaction taken at this edge
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no transaction outstanding: matched %0d count %0d status %0d",
						matched, entry_count, status);
					err_cnt++;
				end else begin
					want = expected_q.pop_front();
					if (matched !== want.matched) begin
						$error("matched: expected %0d, got %0d", want.matched, matched);
						err_cnt++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
						err_cnt++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						err_cnt++;
					end
				end
			end
			if (start && !busy) begin
				want = apply_command(operation, address, prefix_length);
				expected_q.push_back(want);
				if (operation == OP_LOOKUP) begin
					n_lookups++;
					if (want.matched)
						n_hits++;
				end
				if (want.status == STATUS_FULL)
					n_dropped++;
			end
		end
	end

endmodule

### tb/cidr_blocklist_match_tb.sv
// Testbench top for the CIDR blocklist matcher: clock, reset, command stimulus
// and the verdict. Depends on cbl_pkg, cidr_blocklist_match and
// cidr_blocklist_match_checker.
module cidr_blocklist_match_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cbl_pkg::*;

	localparam int         TABLE_DEPTH = MAX_ENTRIES_DEF;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                start         = 1'b0;
	logic [1:0]          operation     = OP_LOOKUP;
	logic [ADDR_W-1:0]   address       = '0;
	logic [PLEN_W-1:0]   prefix_length = '0;
	logic                busy;
	logic                done;
	logic                matched;
	logic [COUNT_W-1:0]  entry_count;
	logic                status;

	int errors;
	int pending;
	int lookups_seen;
	int lookup_hits;
	int adds_dropped;

	// percentage of transactions followed by an idle gap on the command side
	int idle_pct = 0;

	cidr_blocklist_match #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.address      (address),
		.prefix_length(prefix_length),
		.done         (done),
		.matched      (matched),
		.entry_count  (entry_count),
		.status       (status)
	);

	cidr_blocklist_match_checker #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.address      (address),
		.prefix_length(prefix_length),
		.done         (done),
		.matched      (matched),
		.entry_count  (entry_count),
		.status       (status),
		.errors       (errors),
		.pending      (pending),
		.lookups_seen (lookups_seen),
		.lookup_hits  (lookup_hits),
		.adds_dropped (adds_dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one command transaction, then maybe an idle gap with junk on the fields
	task automatic issue(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
		input logic [PLEN_W-1:0] plen);
		start         <= 1'b1;
		operation     <= op;
		address       <= addr;
		prefix_length <= plen;
		do @(posedge clk); while (busy);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start         <= 1'b0;
			operation     <= 2'($urandom());
			address       <= $urandom();
			prefix_length <= 6'($urandom());
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	initial begin
		int                phase_idle [4];
		logic [ADDR_W-1:0] shadow_net [$];
		logic [PLEN_W-1:0] shadow_plen [$];
		logic [ADDR_W-1:0] net;
		logic [PLEN_W-1:0] plen;
		int                pick;
		int                r;
		int                ph;

		// the result side cannot stall, so only the command side idles
		phase_idle = '{0, 51, 0, 37};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, unused code, invalid prefixes, edge masks
		issue(OP_LOOKUP, 32'h0000_0000, 6'd0);
		issue(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63);
		issue(OP_UNUSED, 32'hDEAD_BEEF, 6'd17);
		issue(OP_ADD,    32'h0A00_0000, 6'd8);
		issue(OP_ADD,    32'hC0A8_0101, HOST_PREFIX);
		issue(OP_ADD,    32'h0B00_0000, 6'd33);
		issue(OP_ADD,    32'hFFFF_FFFF, 6'd63);
		issue(OP_LOOKUP, 32'h0A12_3456, 6'd0);
		issue(OP_LOOKUP, 32'h0B00_0000, 6'd0);
		issue(OP_LOOKUP, 32'hC0A8_0101, 6'd0);
		issue(OP_LOOKUP, 32'hC0A8_0100, 6'd0);
		issue(OP_ADD,    32'hFFFF_FFFF, 6'd31);
		issue(OP_LOOKUP, 32'hFFFF_FFFE, 6'd0);
		issue(OP_ADD,    32'h8000_0000, 6'd1);
		issue(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0);
		issue(OP_LOOKUP, 32'h8000_0001, 6'd0);
		issue(OP_CLEAR,  32'hFFFF_FFFF, 6'd63);
		issue(OP_LOOKUP, 32'h0A00_0001, 6'd0);
		issue(OP_ADD,    32'h1234_5678, 6'd0);
		issue(OP_LOOKUP, 32'h0000_0000, 6'd0);
		issue(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0);
		issue(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
		issue(OP_CLEAR,  32'h0000_0000, 6'd0);

		// random: mostly adds and lookups aimed at stored entries
		net = '0;
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			repeat (29) begin
				r = $urandom_range(99);
				if (r < 6) begin
					issue(OP_CLEAR, $urandom(), 6'($urandom()));
					shadow_net.delete();
					shadow_plen.delete();
				end else if (r < 9) begin
					issue(OP_UNUSED, $urandom(), 6'($urandom()));
				end else if (r < 14) begin
					issue(OP_ADD, $urandom(), 6'($urandom_range(33, 63)));
				end else if (r < 52) begin
					net  = $urandom();
					plen = ($urandom_range(99) < 5) ? 6'd0 : 6'($urandom_range(1, 32));
					issue(OP_ADD, net, plen);
					shadow_net.push_back(net);
					shadow_plen.push_back(plen);
				end else if (shadow_net.size() != 0 && $urandom_range(99) < 60) begin
					pick = $urandom_range(shadow_net.size() - 1);
					net  = shadow_net[pick];
					plen = shadow_plen[pick];
					if ($urandom_range(99) < 70 || plen == 0)
						// random host bits below the prefix
						issue(OP_LOOKUP, net ^ ($urandom() >> plen), 6'($urandom()));
					else
						// flip the last prefix bit for a near miss
						issue(OP_LOOKUP, net ^ (32'h8000_0000 >> (plen - 1)),
							6'($urandom()));
				end else begin
					issue(OP_LOOKUP, $urandom(), 6'($urandom()));
				end
			end
		end
		start <= 1'b0;

		// drain, then allow a little slack for any stray result
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("Covered %0d lookups (%0d hits) and %0d dropped adds over directed cases",
			lookups_seen, lookup_hits, adds_dropped);
		$display("and random traffic with command-side gaps of 0, 51 and 37 percent.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
